// File: hdl/assert_macros.svh
// Assertion macros for the scheduler RTL, used by tws_dp.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TWS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("scheduler assertion failed");
`define TWS_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("scheduler forbidden condition seen");
`else
`define TWS_ASSERT(label, clk, rst, prop)
`define TWS_NEVER(label, clk, rst, cond)
`endif
`endif

// File: hdl/tws_pkg.sv
// Package for the timing wheel scheduler: sizes, result codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package tws_pkg;
  // Both sizes must be powers of two for the slot and rounds split.
  localparam int WHEEL_SLOTS  = 32;
  localparam int SLOT_W       = $clog2(WHEEL_SLOTS);
  localparam int POOL_ENTRIES = 32;
  localparam int ENT_W        = $clog2(POOL_ENTRIES);
  localparam int IDX_W        = $clog2(POOL_ENTRIES + 1);
  localparam int MAX_RESULTS  = 32;
  localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(POOL_ENTRIES);

  localparam logic       OP_ADD  = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_EMPTY  = 2'd3;

  typedef struct packed {
    logic accept;
    logic reject;
    logic div_step;
    logic add_init;
    logic add_step;
    logic add_link;
    logic tick_step;
    logic tick_end;
  } tws_cmd_t;

  typedef struct packed {
    logic full;
    logic div_last;
    logic add_stop;
    logic tick_done;
    logic fire_now;
    logic have_pend;
    logic out_free;
  } tws_stat_t;
endpackage

// File: hdl/tws_in_if.sv
// Input channel of the scheduler: valid/ready handshake with the item fields.
// Depends on nothing.
`timescale 1ns / 1ps
interface tws_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] wait_ms;
  logic [7:0]  task_priority;
  logic [31:0] task_tag;
  logic        action_present;
  modport source (output valid, op, wait_ms, task_priority, task_tag, action_present,
                  input ready);
  modport sink (input valid, op, wait_ms, task_priority, task_tag, action_present,
                output ready);
endinterface

// File: hdl/tws_out_if.sv
// Result channel of the scheduler: valid/ready handshake with the result fields.
// Depends on nothing.
`timescale 1ns / 1ps
interface tws_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] fired_tag;
  logic [7:0]  fired_priority;
  logic        fired_action;
  logic        last;
  modport source (output valid, result_kind, fired_tag, fired_priority, fired_action,
                  last, input ready);
  modport sink (input valid, result_kind, fired_tag, fired_priority, fired_action, last,
                output ready);
endinterface

// File: hdl/tws_ctrl.sv
// Sequencer of the scheduler: steps the datapath through add and tick work.
// Depends on tws_pkg.
`timescale 1ns / 1ps
module tws_ctrl
  import tws_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  input  tws_stat_t stat,
  output tws_cmd_t  cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_REJ   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_AINIT = 3'd3;
  localparam logic [2:0] S_AWALK = 3'd4;
  localparam logic [2:0] S_ALINK = 3'd5;
  localparam logic [2:0] S_TWALK = 3'd6;
  localparam logic [2:0] S_TEND  = 3'd7;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_ADD) state_next = stat.full ? S_REJ : S_DIV;
          else state_next = S_TWALK;
        end
      end
      S_REJ: begin
        if (stat.out_free) begin
          cmd.reject = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_AINIT;
      end
      S_AINIT: begin
        cmd.add_init = 1'b1;
        state_next   = S_AWALK;
      end
      S_AWALK: begin
        if (stat.add_stop) state_next = S_ALINK;
        else cmd.add_step = 1'b1;
      end
      S_ALINK: begin
        if (stat.out_free) begin
          cmd.add_link = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_TWALK: begin
        // A firing entry pushes out the one held before it, so it needs room.
        if (stat.tick_done) state_next = S_TEND;
        else if (!(stat.fire_now && stat.have_pend) || stat.out_free) cmd.tick_step = 1'b1;
      end
      S_TEND: begin
        if (stat.out_free) begin
          cmd.tick_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// File: hdl/tws_dp.sv
// Datapath of the scheduler: entry pool, slot lists, serial divider, walk
// registers and the result register. Depends on tws_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tws_dp
  import tws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_op,
  input  logic [31:0] in_wait_ms,
  input  logic [7:0]  in_task_priority,
  input  logic [31:0] in_task_tag,
  input  logic        in_action_present,
  input  tws_cmd_t    cmd,
  output tws_stat_t   stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [31:0] out_fired_tag,
  output logic [7:0]  out_fired_priority,
  output logic        out_fired_action,
  output logic        out_last
);
  logic [15:0]       period;
  logic [SLOT_W-1:0] pos;
  logic [IDX_W-1:0]  free_top;
  logic [IDX_W-1:0]  slot_head [WHEEL_SLOTS];
  logic [IDX_W-1:0]  nxt       [POOL_ENTRIES];
  logic [31:0]       rounds    [POOL_ENTRIES];
  logic [7:0]        prio      [POOL_ENTRIES];
  logic [31:0]       tag       [POOL_ENTRIES];
  logic              act       [POOL_ENTRIES];

  logic [7:0]        new_prio;
  logic [31:0]       new_tag;
  logic              new_act;
  logic [IDX_W-1:0]  idx;
  logic [15:0]       rem;
  logic [31:0]       quo;
  logic [4:0]        dcnt;
  logic [SLOT_W-1:0] slot;
  logic [IDX_W-1:0]  cur, prev, guard;
  logic [CNT_W-1:0]  nfire;
  logic              have_pend;
  logic [31:0]       pend_tag;
  logic [7:0]        pend_prio;
  logic              pend_act;

  logic [ENT_W-1:0]  ce;
  logic              walk_ok, fire_now, out_free, push;
  logic [IDX_W-1:0]  nxt_cur;
  logic [15:0]       period_eff;
  logic [16:0]       shifted, diff;
  logic              ge;
  logic [SLOT_W-1:0] add_slot;

  assign ce         = cur[ENT_W-1:0];
  assign walk_ok    = (cur < NULL_IDX) && (guard < NULL_IDX);
  assign nxt_cur    = nxt[ce];
  assign fire_now   = (rounds[ce] == 32'd0) && (nfire < CNT_W'(MAX_RESULTS));
  assign out_free   = !out_valid || out_ready;
  assign period_eff = (period == 16'd0) ? 16'd1 : period;
  assign shifted    = {rem, quo[31]};
  assign diff       = shifted - {1'b0, period_eff};
  assign ge         = shifted >= {1'b0, period_eff};
  assign add_slot   = pos + quo[SLOT_W-1:0];
  assign push       = cmd.reject || cmd.add_link || cmd.tick_end ||
                      (cmd.tick_step && fire_now && have_pend);

  always_comb begin
    stat.full      = (free_top == NULL_IDX);
    stat.div_last  = (dcnt == 5'd31);
    stat.add_stop  = !(walk_ok && (prio[ce] >= new_prio));
    stat.tick_done = !walk_ok;
    stat.fire_now  = fire_now;
    stat.have_pend = have_pend;
    stat.out_free  = out_free;
  end

  // Period, wheel position, lists and free chain; reset empties slots, fills chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      period   <= 16'd10;
      pos      <= '0;
      free_top <= '0;
      for (int i = 0; i < WHEEL_SLOTS; i++) slot_head[i] <= NULL_IDX;
      for (int i = 0; i < POOL_ENTRIES; i++) nxt[i] <= IDX_W'(i + 1);
    end else begin
      if (cfg_we) period <= cfg_wdata;
      if (cmd.accept && in_op == OP_ADD && free_top != NULL_IDX)
        free_top <= nxt[free_top[ENT_W-1:0]];
      if (cmd.add_link) begin
        nxt[idx[ENT_W-1:0]] <= cur;
        if (prev == NULL_IDX) slot_head[slot] <= idx;
        else nxt[prev[ENT_W-1:0]] <= idx;
      end
      if (cmd.tick_step && fire_now) begin
        if (prev == NULL_IDX) slot_head[slot] <= nxt_cur;
        else nxt[prev[ENT_W-1:0]] <= nxt_cur;
        nxt[ce]  <= free_top;
        free_top <= cur;
      end
      if (cmd.tick_end) pos <= pos + 1'b1;
    end
  end

  // Entry payload and work registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_prio <= in_task_priority;
      new_tag  <= in_task_tag;
      new_act  <= in_action_present;
      idx      <= free_top;
      rem      <= '0;
      quo      <= in_wait_ms;
      dcnt     <= '0;
      slot     <= pos;
      cur      <= slot_head[pos];
      prev     <= NULL_IDX;
      guard    <= '0;
      nfire    <= '0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? diff[15:0] : shifted[15:0];
      quo  <= {quo[30:0], ge};
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.add_init) begin
      rounds[idx[ENT_W-1:0]] <= quo >> SLOT_W;
      prio[idx[ENT_W-1:0]]   <= new_prio;
      tag[idx[ENT_W-1:0]]    <= new_tag;
      act[idx[ENT_W-1:0]]    <= new_act;
      slot                   <= add_slot;
      cur                    <= slot_head[add_slot];
      prev                   <= NULL_IDX;
      guard                  <= '0;
    end
    if (cmd.add_step) begin
      prev  <= cur;
      cur   <= nxt_cur;
      guard <= guard + 1'b1;
    end
    if (cmd.tick_step) begin
      cur   <= nxt_cur;
      guard <= guard + 1'b1;
      if (fire_now) begin
        nfire     <= nfire + 1'b1;
        pend_tag  <= tag[ce];
        pend_prio <= prio[ce];
        pend_act  <= act[ce];
      end else begin
        if (rounds[ce] != 32'd0) rounds[ce] <= rounds[ce] - 32'd1;
        prev <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) have_pend <= 1'b0;
    else if (cmd.accept) have_pend <= 1'b0;
    else if (cmd.tick_step && fire_now) have_pend <= 1'b1;
  end

  // Result register; fired entries are held back by one to know the last flag.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (push) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      priority if (cmd.reject) begin
        out_result_kind    <= KIND_REJECT;
        out_fired_tag      <= '0;
        out_fired_priority <= '0;
        out_fired_action   <= 1'b0;
        out_last           <= 1'b1;
      end else if (cmd.tick_end && !have_pend) begin
        out_result_kind    <= KIND_EMPTY;
        out_fired_tag      <= '0;
        out_fired_priority <= '0;
        out_fired_action   <= 1'b0;
        out_last           <= 1'b1;
      end else if (cmd.tick_end || cmd.tick_step) begin
        out_result_kind    <= KIND_FIRED;
        out_fired_tag      <= pend_tag;
        out_fired_priority <= pend_prio;
        out_fired_action   <= pend_act;
        out_last           <= cmd.tick_end;
      end else begin
        out_result_kind    <= KIND_ACCEPT;
        out_fired_tag      <= '0;
        out_fired_priority <= '0;
        out_fired_action   <= 1'b0;
        out_last           <= 1'b1;
      end
    end
  end

  `TWS_NEVER(a_push_busy, clk, rst, push && out_valid && !out_ready)
  `TWS_NEVER(a_free_range, clk, rst, free_top > NULL_IDX)
  `TWS_ASSERT(a_step_free, clk, rst, (cmd.tick_step && fire_now) |=> (free_top == $past(cur)))
endmodule

// File: hdl/timing_wheel_priority_scheduler_top.sv
// Top level of the timing wheel scheduler: controller plus datapath.
// Depends on tws_pkg, tws_in_if, tws_out_if, tws_ctrl and tws_dp.
//
// Use: items arrive on in_chan (valid/ready). op 0 adds a timer entry with
// wait_ms, task_priority, task_tag and action_present; op 1 is one tick.
// Results leave on out_chan; every item gives one or more results, the final
// one flagged by last. cfg_we with cfg_wdata sets tick_period_ms (zero acts
// as one); write it only while the block is idle.
// Sequence: an add runs a 32-step restoring divider, then walks its slot list
// past every entry that precedes it in priority order before linking in. A
// full pool rejects an add without dividing. A tick walks the current slot
// list one entry per cycle, but a firing entry waits while an earlier fired
// result is held and the result register is busy. One item is worked on at a
// time; in_chan.ready is high only between items.
// Reset (rst, synchronous) empties every slot, puts all pool entries on the
// free list and sets the tick period to 10. When out_chan.ready is low the
// result register holds and the walk waits before the next result.
`timescale 1ns / 1ps
module timing_wheel_priority_scheduler_top
  import tws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  tws_in_if.sink      in_chan,
  tws_out_if.source   out_chan
);
  tws_cmd_t  cmd;
  tws_stat_t stat;

  tws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_chan.valid),
    .in_op    (in_chan.op),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tws_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_op              (in_chan.op),
    .in_wait_ms         (in_chan.wait_ms),
    .in_task_priority   (in_chan.task_priority),
    .in_task_tag        (in_chan.task_tag),
    .in_action_present  (in_chan.action_present),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_result_kind    (out_chan.result_kind),
    .out_fired_tag      (out_chan.fired_tag),
    .out_fired_priority (out_chan.fired_priority),
    .out_fired_action   (out_chan.fired_action),
    .out_last           (out_chan.last)
  );
endmodule

// File: bench/tb_top.sv
// Self-checking bench for the timing wheel scheduler: adds and ticks are driven
// on in_chan, firing order is predicted locally and checked on out_chan.
// Depends on tws_pkg, tws_in_if, tws_out_if and timing_wheel_priority_scheduler_top.
`timescale 1ns / 1ps
module tb_top
  import tws_pkg::*;
();

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag;
    logic [7:0]  prio;
    logic        act;
    logic        last;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  tws_in_if  in_chan ();
  tws_out_if out_chan ();

  timing_wheel_priority_scheduler_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  // Local copy of the wheel state.
  logic [15:0] period_q;
  int unsigned wheel_pos;
  int unsigned free_top;
  int unsigned slot_first [WHEEL_SLOTS];
  int unsigned ent_link [POOL_ENTRIES];
  logic [31:0] ent_rounds [POOL_ENTRIES];
  logic [7:0]  ent_prio [POOL_ENTRIES];
  logic [31:0] ent_tag [POOL_ENTRIES];
  logic        ent_act [POOL_ENTRIES];

  sched_result_t due_results [$];
  int errors = 0;
  int out_idle_pct = 34;
  int in_idle_pct = 34;
  int hold_out = 0;

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void wheel_reset();
    period_q = 16'd10;
    wheel_pos = 0;
    free_top = 0;
    for (int i = 0; i < WHEEL_SLOTS; i++) slot_first[i] = POOL_ENTRIES;
    for (int i = 0; i < POOL_ENTRIES; i++) ent_link[i] = i + 1;
  endfunction

  function automatic void push_result(input logic [1:0] k, input logic [31:0] t,
                                      input logic [7:0] p, input logic a, input logic l);
    sched_result_t r;
    r.kind = k; r.tag = t; r.prio = p; r.act = a; r.last = l;
    due_results.push_back(r);
  endfunction

  function automatic void predict_add(input logic [31:0] dly, input logic [7:0] p,
                                      input logic [31:0] t, input logic a);
    int unsigned idx, prv, cur, slot, guard;
    logic [31:0] ticks, per;
    if (free_top >= POOL_ENTRIES) begin
      push_result(KIND_REJECT, 32'd0, 8'd0, 1'b0, 1'b1);
      return;
    end
    idx = free_top;
    free_top = ent_link[idx];
    per = (period_q == 0) ? 32'd1 : {16'd0, period_q};
    ticks = dly / per;
    ent_rounds[idx] = ticks / WHEEL_SLOTS;
    ent_prio[idx] = p;
    ent_tag[idx] = t;
    ent_act[idx] = a;
    slot = (wheel_pos + ticks % WHEEL_SLOTS) % WHEEL_SLOTS;
    prv = POOL_ENTRIES;
    cur = slot_first[slot];
    guard = 0;
    while (cur < POOL_ENTRIES && ent_prio[cur] >= p && guard < POOL_ENTRIES) begin
      prv = cur;
      cur = ent_link[cur];
      guard++;
    end
    ent_link[idx] = cur;
    if (prv >= POOL_ENTRIES) slot_first[slot] = idx;
    else ent_link[prv] = idx;
    push_result(KIND_ACCEPT, 32'd0, 8'd0, 1'b0, 1'b1);
  endfunction

  function automatic void predict_tick();
    int unsigned slot, prv, cur, nxt, guard;
    int n;
    slot = wheel_pos;
    prv = POOL_ENTRIES;
    cur = slot_first[slot];
    guard = 0;
    n = 0;
    while (cur < POOL_ENTRIES && guard < POOL_ENTRIES) begin
      nxt = ent_link[cur];
      guard++;
      if (ent_rounds[cur] == 0 && n < MAX_RESULTS) begin
        push_result(KIND_FIRED, ent_tag[cur], ent_prio[cur], ent_act[cur], 1'b0);
        n++;
        if (prv >= POOL_ENTRIES) slot_first[slot] = nxt;
        else ent_link[prv] = nxt;
        ent_link[cur] = free_top;
        free_top = cur;
      end else begin
        if (ent_rounds[cur] != 0) ent_rounds[cur]--;
        prv = cur;
      end
      cur = nxt;
    end
    wheel_pos = (slot + 1) % WHEEL_SLOTS;
    if (n == 0) push_result(KIND_EMPTY, 32'd0, 8'd0, 1'b0, 1'b1);
    else due_results[$].last = 1'b1;
  endfunction

  // Sends one item, idling at random beforehand; prediction happens on acceptance.
  task automatic send_item(input logic op, input logic [31:0] dly, input logic [7:0] p,
                           input logic [31:0] t, input logic a);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.op <= op;
    in_chan.wait_ms <= dly;
    in_chan.task_priority <= p;
    in_chan.task_tag <= t;
    in_chan.action_present <= a;
    do @(posedge clk); while (!in_chan.ready);
    if (op == OP_ADD) predict_add(dly, p, t, a);
    else predict_tick();
    @(negedge clk);
    in_chan.valid <= 1'b0;
  endtask

  task automatic send_add(input logic [31:0] dly, input logic [7:0] p);
    send_item(OP_ADD, dly, p, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic send_tick();
    send_item(OP_TICK, $urandom, 8'($urandom), $urandom, 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    while (due_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_period(input logic [15:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    period_q = v;
  endtask

  // Result checker.
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst && out_chan.valid && out_chan.ready) begin
      if (due_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_r = due_results.pop_front();
        if (out_chan.result_kind !== exp_r.kind)
          report($sformatf("kind %0d, want %0d", out_chan.result_kind, exp_r.kind));
        if (out_chan.fired_tag !== exp_r.tag)
          report($sformatf("tag %h, want %h", out_chan.fired_tag, exp_r.tag));
        if (out_chan.fired_priority !== exp_r.prio)
          report($sformatf("priority %0d, want %0d", out_chan.fired_priority, exp_r.prio));
        if (out_chan.fired_action !== exp_r.act)
          report($sformatf("action %b, want %b", out_chan.fired_action, exp_r.act));
        if (out_chan.last !== exp_r.last)
          report($sformatf("last %b, want %b", out_chan.last, exp_r.last));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_out > 0) begin
      out_chan.ready <= 1'b0;
      hold_out <= hold_out - 1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Extremes, empty ticks and rejection when full.
  task automatic test_directed();
    send_tick();
    send_add(32'd0, 8'd0);
    send_add(32'd0, 8'd255);
    send_add(32'd0, 8'd255);
    send_add(32'hFFFF_FFFF, 8'd128);
    send_item(OP_ADD, 32'd5, 8'd7, 32'hFFFF_FFFF, 1'b0);
    send_item(OP_ADD, 32'd9, 8'd7, 32'h0000_0000, 1'b1);
    send_tick();
    send_tick();
    for (int i = 0; i < 31; i++) send_add(32'd320, 8'($urandom_range(3)));
    send_add(32'd320, 8'd1);
    for (int i = 0; i < 12; i++) send_tick();
    wait_drained();
  endtask

  task automatic test_period_extremes();
    write_period(16'd0);
    send_add(32'd3, 8'd9);
    for (int i = 0; i < 4; i++) send_tick();
    write_period(16'hFFFF);
    send_add(32'd65535 * 2, 8'd3);
    send_add(32'hFFFF_FFFF, 8'd4);
    for (int i = 0; i < 4; i++) send_tick();
    write_period(16'd1);
  endtask

  // The receiver holds off while adds keep coming so the block stalls its input.
  task automatic test_backpressure();
    hold_out = 400;
    for (int i = 0; i < 10; i++) send_add($urandom_range(40), 8'($urandom));
    wait_drained();
    for (int i = 0; i < 6; i++) send_tick();
    wait_drained();
  endtask

  // Mostly short delays so entries fire soon; some long ones for rounds.
  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (i == n * 3 / 4) begin
        in_idle_pct = 34;
        out_idle_pct = 34;
      end
      if ($urandom_range(99) < 45) begin
        send_tick();
      end else begin
        case ($urandom_range(9))
          0: send_add($urandom, 8'($urandom));
          1, 2: send_add($urandom_range(200 * period_q), 8'($urandom));
          default: send_add($urandom_range(40 * period_q), 8'($urandom_range(4)));
        endcase
      end
    end
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.op = OP_ADD;
    in_chan.wait_ms = '0;
    in_chan.task_priority = '0;
    in_chan.task_tag = '0;
    in_chan.action_present = 1'b0;
    out_chan.ready = 1'b0;
    wheel_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_period_extremes();
    test_backpressure();
    test_random(50);
    write_period(16'd3);
    test_random(50);
    write_period(16'd10);
    test_random(30);
    wait_drained();
    if (errors == 0) $display("timing_wheel_priority_scheduler_top verification clean");
    else $display("timing_wheel_priority_scheduler_top verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("timing_wheel_priority_scheduler_top verification failed");
    $finish;
  end
endmodule
